// ===== hdl/fqs_pkg.sv =====
// Types and constants shared by the bounded queue with value search.
package fqs_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_FIND_CMP,
        ST_FIND_END
    } t_state;

    // One result item; the first member sits in the highest bits.
    typedef struct packed {
        logic [31:0] back_value;
        logic [31:0] front_value;
        logic        is_full;
        logic        is_empty;
        logic [4:0]  count;
        logic        match_valid;
        logic [3:0]  match_index;
        logic        ok;
    } t_result;

    localparam int RES_W       = $bits(t_result);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int IN_TDATA_W  = 32;
    localparam int LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// ===== hdl/fifo_queue_with_search.sv =====
// Bounded queue of 32-bit words in a synchronous memory, with a value search.
// Push, status, refused pop and find on an empty queue show their result in the cycle after
// the item is accepted; a successful pop first reads the new front from memory in ST_POP_RD.
// A find on a non-empty queue scans the occupied entries through the single memory read port,
// emitting one result per match, or one not-found result; a held match waits for a free output.
// A new item is taken only when the sequencer is idle and the result register is free.
// Reset (synchronous, active low) empties the queue and sets the limit to 16; the memory is
// not cleared, and the word read past the front by a pop that empties the queue is dropped.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel: capacity limit.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LIMIT_W-1:0]     i_cfg_data,
    // Input items.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [1:0]             s_axis_tuser,   // [1:0] cmd
    // Result items.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] ok, [4:1] match_index, [5] match_valid, [10:6] count, [11] is_empty,
    // [12] is_full, [44:13] front_value, [76:45] back_value, [79:77] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast    // last_in_run
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW_F  = $clog2(DEPTH + 1);
    localparam int CW    = (CW_F < LIMIT_W) ? CW_F : LIMIT_W;

    // Ring increment with wrap at the built depth.
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        f_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // Build one result from the post-operation queue view.
    function automatic t_result f_res(input logic ok, input logic [3:0] idx,
                                      input logic mv, input logic [CW-1:0] cnt,
                                      input logic [CW-1:0] lim,
                                      input logic [31:0] front,
                                      input logic [31:0] back);
        t_result r;
        r.ok          = ok;
        r.match_index = idx;
        r.match_valid = mv;
        r.count       = LIMIT_W'(cnt);
        r.is_empty    = (cnt == '0);
        r.is_full     = (cnt >= lim);
        r.front_value = (cnt == '0) ? 32'd0 : front;
        r.back_value  = (cnt == '0) ? 32'd0 : back;
        f_res = r;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [LIMIT_W-1:0]  r_limit;
    logic [31:0]         r_front, n_front;
    logic [31:0]         r_back, n_back;
    logic [31:0]         r_key, n_key;
    logic [AW-1:0]       r_scan_addr, n_scan_addr;
    logic [CW-1:0]       r_scan_pos, n_scan_pos;
    logic                r_pend_valid, n_pend_valid;
    logic [CW-1:0]       r_pend_pos, n_pend_pos;
    logic                r_out_valid;
    t_result             r_res, n_res;
    logic                r_last, n_last;
    logic                w_load;

    // Entry memory, one write and one registered read port.
    logic [31:0]         r_mem [DEPTH];
    logic [31:0]         r_rdata;
    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;

    logic                w_out_free, w_accept;
    logic [CW-1:0]       w_eff;
    logic [AW:0]         w_sum;
    logic [AW-1:0]       w_tail;
    logic                w_hit, w_at_end;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Effective limit: the configured value saturated at the built depth.
    assign w_eff = (32'(r_limit) > DEPTH) ? CW'(DEPTH) : CW'(r_limit);

    // Ring slot just past the back entry.
    assign w_sum  = {1'b0, r_head} + (AW + 1)'(r_count);
    assign w_tail = (w_sum >= (AW + 1)'(DEPTH)) ? AW'(w_sum - (AW + 1)'(DEPTH))
                                                 : AW'(w_sum);

    // Scan compare on the registered word from the memory read port.
    assign w_hit    = (r_rdata == r_key);
    assign w_at_end = (r_scan_pos == r_count - CW'(1));

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Entry memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // State and queue control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_back      <= n_back;
        r_key       <= n_key;
        r_scan_addr <= n_scan_addr;
        r_scan_pos  <= n_scan_pos;
        r_pend_pos  <= n_pend_pos;
        if (w_load) begin
            r_res  <= n_res;
            r_last <= n_last;
        end
    end

    // Sequencer: queue operations, scan and result generation.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_key        = r_key;
        n_scan_addr  = r_scan_addr;
        n_scan_pos   = r_scan_pos;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_res        = r_res;
        n_last       = 1'b1;
        w_load       = 1'b0;
        w_we         = 1'b0;
        w_waddr      = w_tail;
        w_re         = 1'b0;
        w_raddr      = r_head;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_cmd'(s_axis_tuser))
                        CMD_PUSH: begin
                            if (r_count < w_eff) begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                n_back  = s_axis_tdata;
                                if (r_count == '0) begin
                                    n_front = s_axis_tdata;
                                end
                            end
                            w_load = 1'b1;
                            n_res  = f_res(r_count < w_eff, 4'd0, 1'b0, n_count, w_eff,
                                           n_front, n_back);
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                n_head  = f_inc(r_head);
                                n_count = r_count - CW'(1);
                                w_re    = 1'b1;
                                w_raddr = f_inc(r_head);
                                n_state = ST_POP_RD;
                            end else begin
                                w_load = 1'b1;
                                n_res  = f_res(1'b0, 4'd0, 1'b0, r_count, w_eff,
                                               r_front, r_back);
                            end
                        end
                        CMD_FIND: begin
                            n_key = s_axis_tdata;
                            if (r_count == '0) begin
                                w_load = 1'b1;
                                n_res  = f_res(1'b0, 4'd0, 1'b0, r_count, w_eff,
                                               r_front, r_back);
                            end else begin
                                w_re         = 1'b1;
                                w_raddr      = r_head;
                                n_scan_addr  = r_head;
                                n_scan_pos   = '0;
                                n_pend_valid = 1'b0;
                                n_state      = ST_FIND_CMP;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                            n_res  = f_res(1'b1, 4'd0, 1'b0, r_count, w_eff,
                                           r_front, r_back);
                        end
                    endcase
                end
            end

            // The new front word arrives from memory.
            ST_POP_RD: begin
                if (w_out_free) begin
                    n_front = r_rdata;
                    w_load  = 1'b1;
                    n_res   = f_res(1'b1, 4'd0, 1'b0, r_count, w_eff, r_rdata, r_back);
                    n_state = ST_IDLE;
                end
            end

            // Compare one entry; a held match is sent once a later one is found.
            ST_FIND_CMP: begin
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    if (w_hit && r_pend_valid) begin
                        w_load = 1'b1;
                        n_last = 1'b0;
                        n_res  = f_res(1'b1, 4'(r_pend_pos), 1'b1, r_count, w_eff,
                                       r_front, r_back);
                    end
                    if (w_hit) begin
                        n_pend_valid = 1'b1;
                        n_pend_pos   = r_scan_pos;
                    end
                    if (w_at_end) begin
                        n_state = ST_FIND_END;
                    end else begin
                        w_re        = 1'b1;
                        w_raddr     = f_inc(r_scan_addr);
                        n_scan_addr = f_inc(r_scan_addr);
                        n_scan_pos  = r_scan_pos + CW'(1);
                    end
                end
            end

            // Final result of the search, or not-found.
            ST_FIND_END: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_res   = f_res(r_pend_valid, r_pend_valid ? 4'(r_pend_pos) : 4'd0,
                                    r_pend_valid, r_count, w_eff, r_front, r_back);
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_res);
    assign m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    // The queue never holds more entries than the memory has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("entry count exceeds depth");

    // A push below the limit adds exactly one entry.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == CMD_PUSH) && (r_count < w_eff))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add one entry");

    // A search leaves the queue untouched.
    a_find_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIND_CMP) || (r_state == ST_FIND_END))
        |=> ($stable(r_head) && $stable(r_count)))
        else $error("queue changed during a search");

    // Only a real match can be followed by more results of the same item.
    a_nonlast_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_res.match_valid && r_res.ok))
        else $error("non-final result without a match");

    // An empty queue reports zero front and back values.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.is_empty)
        |-> ((r_res.front_value == 32'd0) && (r_res.back_value == 32'd0)))
        else $error("empty queue reports nonzero values");
`endif

endmodule

// ===== tb/sv/fqs_checker.sv =====
// Watches the queue's channels, predicts every result item and compares it.
module fqs_checker
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [LIMIT_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [1:0]             i_in_cmd,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic                   i_out_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results_seen,
    output int                     o_matches_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result item together with its end-of-run flag.
    typedef struct {
        t_result fields;
        logic    last;
    } t_due;

    t_due        results_due[$];
    logic [31:0] shadow_words[DEPTH];
    int          shadow_head = 0;
    int          shadow_count = 0;
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
    int          mismatches = 0;
    int          results_seen = 0;
    int          matches_seen = 0;

    assign o_fail_count   = mismatches;
    assign o_results_seen = results_seen;
    assign o_matches_seen = matches_seen;

    // A limit above the built depth behaves as the depth itself.
    function automatic int usable_limit();
        return (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
    endfunction

    function automatic int slot(int pos);
        return (shadow_head + pos) % DEPTH;
    endfunction

    // Status part of a result as seen after the operation.
    function automatic t_result status_word(logic ok, logic [3:0] idx, logic hit);
        t_result r;
        r = '0;
        r.ok          = ok;
        r.match_index = idx;
        r.match_valid = hit;
        r.count       = shadow_count[4:0];
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count >= usable_limit());
        if (shadow_count != 0) begin
            r.front_value = shadow_words[slot(0)];
            r.back_value  = shadow_words[slot(shadow_count - 1)];
        end
        return r;
    endfunction

    // Applies one command to the shadow queue and queues the results it causes.
    task automatic apply_queue_op(t_cmd cmd, logic [31:0] word);
        t_due d;
        int   hits[$];
        logic ok;
        ok = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_count < usable_limit()) begin
                    shadow_words[slot(shadow_count)] = word;
                    shadow_count++;
                    ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (shadow_count > 0) begin
                    shadow_head = slot(1);
                    shadow_count--;
                    ok = 1'b1;
                end
            end
            CMD_FIND: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_words[slot(i)] == word) hits.push_back(i);
                end
            end
            default: ok = 1'b1;
        endcase
        if (hits.size() > 0) begin
            foreach (hits[k]) begin
                d.fields = status_word(1'b1, 4'(hits[k]), 1'b1);
                d.last   = (k == hits.size() - 1);
                results_due.push_back(d);
            end
        end else begin
            // Other commands, or a find without a match, give one result; a find without a match has ok low.
            d.fields = status_word(ok, 4'd0, 1'b0);
            d.last   = 1'b1;
            results_due.push_back(d);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin : watch
        t_result got;
        t_due    want;
        if (!i_rst_n) begin
            shadow_head  = 0;
            shadow_count = 0;
            shadow_limit = LIMIT_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) shadow_limit = i_cfg_data;
            if (i_in_valid && i_in_ready) apply_queue_op(t_cmd'(i_in_cmd), i_in_data);
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data[RES_W-1:0]);
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("result item arrived with no result expected");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (want.fields.match_valid) matches_seen++;
                    check_field("ok", 32'(want.fields.ok), 32'(got.ok));
                    check_field("match_index", 32'(want.fields.match_index),
                                32'(got.match_index));
                    check_field("match_valid", 32'(want.fields.match_valid),
                                32'(got.match_valid));
                    check_field("last_in_run", 32'(want.last), 32'(i_out_last));
                    check_field("count", 32'(want.fields.count), 32'(got.count));
                    check_field("is_empty", 32'(want.fields.is_empty), 32'(got.is_empty));
                    check_field("is_full", 32'(want.fields.is_full), 32'(got.is_full));
                    check_field("front_value", want.fields.front_value, got.front_value);
                    check_field("back_value", want.fields.back_value, got.back_value);
                    check_field("padding", '0, 32'(i_out_data[OUT_TDATA_W-1:RES_W]));
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== tb/sv/tb_fifo_queue_with_search.sv =====
// Stimulus and verdict for the bounded queue with value search.
module tb_fifo_queue_with_search
    import fqs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 55;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [LIMIT_W-1:0]     i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int fail_count;
    int pending;
    int results_seen;
    int matches_seen;
    int cycle_count = 0;
    int items_by_cmd[4] = '{0, 0, 0, 0};
    int limit_settings = 0;
    bit quiet = 1'b0;

    fifo_queue_with_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fqs_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_cmd       (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_last     (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_matches_seen (matches_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: random ready bursts, always ready in the quiet part.
    initial begin : result_sink
        int   n;
        logic r;
        forever begin
            if (quiet) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = ($urandom_range(0, 2) != 0);
                n = $urandom_range(1, 16);
                m_axis_tready <= r;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic pause_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one item, waits for its handshake, then maybe idles a while.
    task automatic send_cmd(t_cmd cmd, logic [31:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_by_cmd[cmd]++;
        if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 16));
    endtask

    // Holds the sender until every predicted result has come out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    // Mostly a few extreme words so that finds hit, otherwise anything.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4, 5: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Alternates between filling and draining so the queue reaches both ends.
    function automatic t_cmd pick_cmd(bit growing);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (growing) begin
            if (roll < 55) return CMD_PUSH;
            if (roll < 70) return CMD_POP;
            if (roll < 90) return CMD_FIND;
        end else begin
            if (roll < 15) return CMD_PUSH;
            if (roll < 60) return CMD_POP;
            if (roll < 90) return CMD_FIND;
        end
        return CMD_STATUS;
    endfunction

    initial begin : stimulus
        logic [LIMIT_W-1:0] phase_limits[6];
        logic [31:0]        fill_word;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_STATUS;
        phase_limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd9, 5'd0};
        phase_limits[5] = LIMIT_W'($urandom_range(0, 31));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty queue, extreme words, duplicates and limits.
        write_limit(5'd16);
        send_cmd(CMD_STATUS, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
        send_cmd(CMD_FIND, 32'h0000_0000);
        send_cmd(CMD_PUSH, 32'h8000_0000);
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
        send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
        send_cmd(CMD_FIND, 32'h7FFF_FFFF);
        send_cmd(CMD_FIND, 32'h0000_0001);
        send_cmd(CMD_FIND, 32'h8000_0000);
        send_cmd(CMD_POP, 32'hFFFF_FFFF);
        send_cmd(CMD_STATUS, 32'hFFFF_FFFF);
        // Limit lowered below the count: the queue reads full, nothing is lost.
        settle();
        write_limit(5'd2);
        send_cmd(CMD_PUSH, 32'h0000_0005);
        send_cmd(CMD_STATUS, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
        send_cmd(CMD_PUSH, 32'h1234_5678);
        send_cmd(CMD_PUSH, 32'hEDCB_A987);
        send_cmd(CMD_POP, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
        // A zero limit refuses every push, even on an empty queue.
        settle();
        write_limit(5'd0);
        send_cmd(CMD_PUSH, 32'h5555_5555);
        send_cmd(CMD_STATUS, 32'hAAAA_AAAA);
        send_cmd(CMD_FIND, 32'h0000_0000);

        // Random phases, one per limit setting; the last one runs without idling.
        foreach (phase_limits[p]) begin
            settle();
            if (p == 5) quiet = 1'b1;
            write_limit(phase_limits[p]);
            // Large limits start by filling the queue with one word to get long runs.
            if (phase_limits[p] >= 16) begin
                while (pending != 0) @(posedge i_clk);
                fill_word = pick_word();
                for (int k = 0; k < 16; k++) send_cmd(CMD_PUSH, fill_word);
                send_cmd(CMD_FIND, fill_word);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_cmd(pick_cmd(((k / 12) % 2) == 0), pick_word());
                if (!quiet && $urandom_range(0, 49) == 0) settle();
            end
        end

        settle();
        $display("Covered %0d push, %0d pop, %0d find and %0d status items over %0d limits.",
                 items_by_cmd[CMD_PUSH], items_by_cmd[CMD_POP], items_by_cmd[CMD_FIND],
                 items_by_cmd[CMD_STATUS], limit_settings);
        $display("Compared %0d result items, %0d of them search matches.",
                 results_seen, matches_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
